[hw/rtl/pscd_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pscd_pkg
// Types and constants shared by the PIO sector disk controller.
// ----------------------------------------------------------------------------
package pscd_pkg;

	// Transfer kinds on the input stream
	typedef enum logic [1:0] {
		KIND_BUS_READ   = 2'd0,
		KIND_BUS_WRITE  = 2'd1,
		KIND_FILL_BYTE  = 2'd2,
		KIND_FETCH_END  = 2'd3
	} kind_t;

	// Register offsets inside the bus window
	localparam logic [31:0] OFF_LBA    = 32'h0000_0004;
	localparam logic [31:0] OFF_COUNT  = 32'h0000_0008;
	localparam logic [31:0] OFF_CMD    = 32'h0000_000C;
	localparam logic [31:0] OFF_STATUS = 32'h0000_0010;
	localparam logic [31:0] OFF_DATA   = 32'h0000_0200;

	// Status codes
	localparam logic [2:0] ST_IDLE = 3'b000;
	localparam logic [2:0] ST_BUSY = 3'b001;
	localparam logic [2:0] ST_DRQ  = 3'b010;
	localparam logic [2:0] ST_ERR  = 3'b100;

	// Command bits: READ together with GO starts a fetch
	localparam logic [31:0] CMD_RD    = 32'h0000_0001;
	localparam logic [31:0] CMD_GO    = 32'h0000_0080;
	localparam logic [31:0] CMD_START = CMD_RD | CMD_GO;

	// Configuration register index (paddr[2])
	localparam logic CFG_IDX_WINDOW_BASE = 1'b0;

	// Stream widths
	localparam int S_DATA_W = 88;
	localparam int M_DATA_W = 72;

	// Stage 1 control and payload, alongside the registered bank reads
	typedef struct packed {
		logic        is_data;
		logic [31:0] reg_word;
		logic [1:0]  rot;
		logic [3:0]  byte_ok;
		logic        req;
		logic [31:0] lba;
		logic [2:0]  status;
	} s1_info_t;

endpackage : pscd_pkg
`default_nettype wire

[hw/rtl/pio_sector_disk_controller_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pio_sector_disk_controller_unit
// Register-mapped programmed-I/O sector disk controller with a banked
// sector buffer memory.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Handshake          Contents
// s_*       in   tvalid/tready      tuser: kind; tdata: bus access or media item
// m_*       out  tvalid/tready      tuser: fetch_request; tdata: read data, lba, status
// APB       in   psel/penable/...   window_base at byte address 0
//
// Cycles: one transfer is taken every cycle while s_tready is high. An item is
// registered in the buffer read stage (banked memory with a registered read)
// and then in the output register, which offers its result transfer.
// Reset: after arst_n releases, a clearing pass zeroes the buffer, one row of
// four bytes per cycle; s_tready stays low during it. Stalls: m_tready low
// holds the output register and the stage behind it; outside the clearing
// pass, s_tready drops only when both are full.
//
// The sector buffer is split into four byte banks, bank = position mod 4, so
// an unaligned word reads each bank once. Register state (LBA, count, status)
// is updated at the input transfer, and buffer writes land at that same edge,
// so a following read transfer always sees them without forwarding.
// ----------------------------------------------------------------------------
module pio_sector_disk_controller_unit
	import pscd_pkg::*;
#(
	parameter int SECTOR_BYTES = 512
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,

	// tdata: bus_address[31:0], write_value[63:32], media_present[64],
	//        fill_index[73:65], fill_byte[81:74], fetch_failed[82], zero pad
	input  wire logic [S_DATA_W-1:0]  s_tdata,
	// tuser: kind[1:0]
	input  wire logic [1:0]           s_tuser,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,

	// tdata: read_data[31:0], fetch_lba[63:32], status_now[66:64], zero pad
	output logic [M_DATA_W-1:0]       m_tdata,
	// tuser: fetch_request[0]
	output logic                      m_tuser,
	output logic                      m_tvalid,
	input  wire logic                 m_tready,

	input  wire logic                 psel,
	input  wire logic                 penable,
	input  wire logic                 pwrite,
	input  wire logic [2:0]           paddr,
	input  wire logic [31:0]          pwdata,
	output logic [31:0]               prdata,
	output logic                      pready
);

	localparam int POS_W = $clog2(SECTOR_BYTES);
	localparam int ROW_W = POS_W - 2;
	localparam int ROWS  = (SECTOR_BYTES + 3) / 4;
	localparam logic [31:0]      SECTOR_LIMIT = 32'(SECTOR_BYTES);
	localparam logic [ROW_W:0]   ROWS_LIMIT   = (ROW_W + 1)'(ROWS);
	localparam logic [ROW_W-1:0] LAST_ROW     = ROW_W'(ROWS - 1);
	localparam logic [POS_W:0]   POS_LIMIT    = (POS_W + 1)'(SECTOR_BYTES);

	// ------------------------------------------------------------------
	// Configuration port
	// ------------------------------------------------------------------
	logic [31:0] window_base_q;
	logic        cfg_we;

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && pready && (paddr[2] == CFG_IDX_WINDOW_BASE);
	assign prdata = (paddr[2] == CFG_IDX_WINDOW_BASE) ? window_base_q : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_base_q <= 32'd0;
		end else if (cfg_we) begin
			window_base_q <= pwdata;
		end
	end

	// ------------------------------------------------------------------
	// Input unpack
	// ------------------------------------------------------------------
	kind_t       in_kind;
	logic [31:0] in_addr;
	logic [31:0] in_wval;
	logic        in_media;
	logic [8:0]  in_fidx;
	logic [7:0]  in_fbyte;
	logic        in_failed;

	assign in_kind   = kind_t'(s_tuser);
	assign in_addr   = s_tdata[31:0];
	assign in_wval   = s_tdata[63:32];
	assign in_media  = s_tdata[64];
	assign in_fidx   = s_tdata[73:65];
	assign in_fbyte  = s_tdata[81:74];
	assign in_failed = s_tdata[82];

	// ------------------------------------------------------------------
	// Handshake and pipeline control
	// ------------------------------------------------------------------
	logic clr_q;
	logic valid_s1;
	logic m_valid_q;
	logic out_adv;
	logic s1_adv;
	logic s_accept;

	assign out_adv  = !m_valid_q || m_tready;
	assign s1_adv   = valid_s1 && out_adv;
	assign s_tready = !clr_q && (!valid_s1 || out_adv);
	assign s_accept = s_tvalid && s_tready;

	// ------------------------------------------------------------------
	// Address decode
	// ------------------------------------------------------------------
	logic [31:0]      offset;
	logic [31:0]      data_off;
	logic             in_window;
	logic [POS_W-1:0] pos;
	logic [ROW_W-1:0] row0;
	logic [ROW_W:0]   row_next;
	logic [ROW_W-1:0] row_hi;
	logic [3:0]       byte_ok;
	logic [3:0][ROW_W-1:0] rd_row;

	assign offset    = in_addr - window_base_q;
	assign data_off  = offset - OFF_DATA;
	assign in_window = (offset >= OFF_DATA) && (data_off < SECTOR_LIMIT);
	assign pos       = data_off[POS_W-1:0];
	assign row0      = pos[POS_W-1:2];
	assign row_next  = {1'b0, row0} + {{ROW_W{1'b0}}, 1'b1};
	// Past the last row the byte is masked anyway; keep the address in range.
	assign row_hi    = (row_next < ROWS_LIMIT) ? row_next[ROW_W-1:0] : row0;

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			byte_ok[k] = ({1'b0, pos} + (POS_W + 1)'(k)) < POS_LIMIT;
			// Banks below the start bank hold the bytes that spill into the next row
			rd_row[k]  = (2'(k) < pos[1:0]) ? row_hi : row0;
		end
	end

	// ------------------------------------------------------------------
	// Register state update
	// ------------------------------------------------------------------
	logic [31:0] lba_q;
	logic [31:0] count_q;
	logic [2:0]  status_q;
	logic [31:0] lba_d;
	logic [31:0] count_d;
	logic [2:0]  status_d;
	logic        req_d;
	logic [31:0] rlba_d;
	logic [31:0] reg_rdata;
	logic        fill_ok;

	assign fill_ok = status_q[0] && ({23'd0, in_fidx} < SECTOR_LIMIT);

	always_comb begin
		lba_d    = lba_q;
		count_d  = count_q;
		status_d = status_q;
		req_d    = 1'b0;
		rlba_d   = 32'd0;
		unique case (in_kind)
			KIND_BUS_WRITE: begin
				if (offset == OFF_LBA) begin
					lba_d = in_wval;
				end else if (offset == OFF_COUNT) begin
					count_d = (in_wval != 32'd0) ? in_wval : 32'd1;
				end else if (offset == OFF_CMD) begin
					if ((in_wval & CMD_START) == CMD_START) begin
						if (!in_media) begin
							status_d = ST_ERR;
						end else begin
							status_d = ST_BUSY;
							req_d    = 1'b1;
							rlba_d   = lba_q;
						end
					end
				end
			end
			KIND_FETCH_END: begin
				if (status_q[0]) begin
					status_d = in_failed ? ST_ERR : ST_DRQ;
				end
			end
			KIND_BUS_READ, KIND_FILL_BYTE: begin
			end
			default: begin
			end
		endcase
	end

	// Register read value; the data window and unmapped offsets give zero here
	always_comb begin
		priority if (offset == OFF_LBA) begin
			reg_rdata = lba_q;
		end else if (offset == OFF_COUNT) begin
			reg_rdata = count_q;
		end else if (offset == OFF_STATUS) begin
			reg_rdata = {29'd0, status_q};
		end else begin
			reg_rdata = 32'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lba_q    <= 32'd0;
			count_q  <= 32'd1;
			status_q <= ST_IDLE;
		end else if (s_accept) begin
			lba_q    <= lba_d;
			count_q  <= count_d;
			status_q <= status_d;
		end
	end

	// ------------------------------------------------------------------
	// Sector buffer: four byte banks with a clearing pass after reset
	// ------------------------------------------------------------------
	logic [ROW_W-1:0]       clr_row_q;
	logic                   fill_we;
	logic [ROW_W+6:0]       fill_row_wide;
	logic [ROW_W-1:0]       wr_row;
	logic [7:0]             wr_byte;
	logic [3:0]             bank_we;
	logic [3:0][7:0]        bank_rd_s1;

	assign fill_we       = s_accept && (in_kind == KIND_FILL_BYTE) && fill_ok;
	assign fill_row_wide = {{ROW_W{1'b0}}, in_fidx[8:2]};
	assign wr_row        = clr_q ? clr_row_q : fill_row_wide[ROW_W-1:0];
	assign wr_byte       = clr_q ? 8'd0 : in_fbyte;

	always_comb begin
		for (int b = 0; b < 4; b++) begin
			bank_we[b] = clr_q || (fill_we && (in_fidx[1:0] == 2'(b)));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_row_q <= '0;
		end else if (clr_q) begin
			if (clr_row_q == LAST_ROW) begin
				clr_q <= 1'b0;
			end else begin
				clr_row_q <= clr_row_q + ROW_W'(1);
			end
		end
	end

	for (genvar b = 0; b < 4; b++) begin : g_bank
		logic [7:0] bank_mem [ROWS];
		logic [7:0] rd_s1;

		always_ff @(posedge clk) begin
			if (bank_we[b]) begin
				bank_mem[wr_row] <= wr_byte;
			end
			if (s_accept) begin
				rd_s1 <= bank_mem[rd_row[b]];
			end
		end

		assign bank_rd_s1[b] = rd_s1;
	end

	// ------------------------------------------------------------------
	// Stage 1: hold decode results beside the bank reads
	// ------------------------------------------------------------------
	s1_info_t info_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			info_s1.is_data  <= (in_kind == KIND_BUS_READ) && in_window;
			info_s1.reg_word <= (in_kind == KIND_BUS_READ) ? reg_rdata : 32'd0;
			info_s1.rot      <= pos[1:0];
			info_s1.byte_ok  <= byte_ok;
			info_s1.req      <= req_d;
			info_s1.lba      <= rlba_d;
			info_s1.status   <= status_d;
		end
	end

	// ------------------------------------------------------------------
	// Word assembly and output register
	// ------------------------------------------------------------------
	logic [31:0] word_s1;
	logic [31:0] rdata_s1;

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			word_s1[8*k +: 8] = info_s1.byte_ok[k] ? bank_rd_s1[info_s1.rot + 2'(k)] : 8'd0;
		end
	end

	assign rdata_s1 = info_s1.is_data ? word_s1 : info_s1.reg_word;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (s1_adv) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	logic [M_DATA_W-1:0] m_data_q;
	logic                m_user_q;

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			m_data_q <= {5'd0, info_s1.status, info_s1.lba, rdata_s1};
			m_user_q <= info_s1.req;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_user_q;

endmodule : pio_sector_disk_controller_unit
`default_nettype wire
